@@ rtl/core/rmmq_pkg.sv @@
// Shared types and codes for the range min/max query table.
package rmmq_pkg;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_RANGE = 2'd1,
      ST_UNBUILT   = 2'd2
   } status_type;

   localparam int unsigned CountBits = 11;
   localparam int unsigned FieldBits = 10;
   localparam int unsigned OutBits   = 32;

   // Register map: byte address 0 holds element_count
   localparam logic [1:0] CsrElementCount = 2'd0;

endpackage

@@ rtl/core/range_min_max_query_table.sv @@
// Top level of the range min/max query table.
// Writes and queries answer through the front request register and the back-end result
// register; one request per cycle while busy is low. A build answers when the single
// build sequencer has filled its levels (up to LEVELS-1 levels).
// busy is high through a build; the receiver cannot stall results. Reset clears
// the built flag and sets element_count to 1024; table contents undefined until written.
module range_min_max_query_table
   import rmmq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned LEVELS = 11,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [FieldBits-1:0]  req_index,
   input  logic [OutBits-1:0]    req_value,
   input  logic [FieldBits-1:0]  req_left,
   input  logic [FieldBits-1:0]  req_right,
   output logic                  rsp_strobe,
   output logic [1:0]            rsp_status,
   output logic [OutBits-1:0]    rsp_range_min,
   output logic [OutBits-1:0]    rsp_range_max,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [1:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned IdxBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // level counter must also hold LEVELS itself
   localparam int unsigned LvlBits = $clog2(LEVELS + 1);

   logic [CountBits-1:0] count_ff;
   logic built_ff;
   logic [CountBits-1:0] count_used;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == CsrElementCount;
   assign csr_prdata = (csr_paddr == CsrElementCount) ? 32'(count_ff) : '0;
   assign count_used = (32'(count_ff) > DEPTH) ? CountBits'(DEPTH) : count_ff;

   logic q_valid, q_store, build_busy, build_done, accept;
   op_type q_op;
   status_type q_status, st;
   logic [LvlBits-1:0] q_level;
   logic [IdxBits-1:0] q_a, q_b;
   logic [VALUE_BITS-1:0] q_value;

   assign accept = start && !busy;
   assign busy = build_busy;

   // built flag: set at build end, cleared by writes and count updates
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CountBits'(1024);
         built_ff <= 1'b0;
      end else begin
         if (csr_wr) count_ff <= csr_pwdata[CountBits-1:0];
         if (csr_wr || (accept && op_type'(req_operation) == OP_WRITE)) built_ff <= 1'b0;
         else if (build_done) built_ff <= 1'b1;
      end
   end

   rmmq_front #(.DEPTH(DEPTH), .LEVELS(LEVELS), .VALUE_BITS(VALUE_BITS),
                .IDX_BITS(IdxBits), .LVL_BITS(LvlBits)) u_front (
      .clock, .reset, .start(accept), .op(req_operation), .index(req_index),
      .value(VALUE_BITS'(req_value)), .left(req_left), .right(req_right),
      .count_used, .built(built_ff), .q_valid, .q_op, .q_status, .q_level,
      .q_addr_a(q_a), .q_addr_b(q_b), .q_store, .q_value
   );

   rmmq_back #(.DEPTH(DEPTH), .LEVELS(LEVELS), .VALUE_BITS(VALUE_BITS),
               .IDX_BITS(IdxBits), .LVL_BITS(LvlBits)) u_back (
      .clock, .reset, .q_valid, .q_op, .q_status, .q_level, .q_addr_a(q_a),
      .q_addr_b(q_b), .q_store, .q_value, .count_used, .build_busy, .build_done,
      .rsp_strobe, .rsp_status(st), .rsp_min(rsp_range_min), .rsp_max(rsp_range_max)
   );

   assign rsp_status = st;

endmodule

@@ rtl/core/rmmq_front.sv @@
// Front end: accepts requests, checks range and level, registers classified work.
module rmmq_front
   import rmmq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned LEVELS = 11,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned IDX_BITS = 10,
   parameter int unsigned LVL_BITS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             op,
   input  logic [FieldBits-1:0]   index,
   input  logic [VALUE_BITS-1:0]  value,
   input  logic [FieldBits-1:0]   left,
   input  logic [FieldBits-1:0]   right,
   input  logic [CountBits-1:0]   count_used,
   input  logic                   built,
   output logic                   q_valid,
   output op_type                 q_op,
   output status_type             q_status,
   output logic [LVL_BITS-1:0]    q_level,
   output logic [IDX_BITS-1:0]    q_addr_a,
   output logic [IDX_BITS-1:0]    q_addr_b,
   output logic                   q_store,
   output logic [VALUE_BITS-1:0]  q_value
);

   // wide enough for any floor(log2) of a range length
   localparam int unsigned KBits = $clog2(FieldBits + 1);

   logic [FieldBits:0] len;
   logic [KBits-1:0] k_raw;
   logic [LVL_BITS-1:0] k;
   logic [FieldBits:0] second;
   status_type st;

   always_comb begin
      len = {1'b0, right} - {1'b0, left} + 1'b1;
      // floor(log2(len)): priority scan over all bits of the length
      k_raw = '0;
      for (int b = 0; b <= FieldBits; b++) begin
         if (len[b]) k_raw = KBits'(b);
      end
      k = (32'(k_raw) >= LEVELS) ? LVL_BITS'(LEVELS - 1) : LVL_BITS'(k_raw);
      second = {1'b0, right} + 1'b1 - ((FieldBits+1)'(1) << k);
      if (!built) st = ST_UNBUILT;
      else if (left > right || {1'b0, right} >= count_used) st = ST_BAD_RANGE;
      else st = ST_OK;
   end

   // Classified request register feeding the back end
   logic q_valid_ff;
   op_type q_op_ff;
   status_type q_status_ff;
   logic [LVL_BITS-1:0] q_level_ff;
   logic [IDX_BITS-1:0] q_addr_a_ff, q_addr_b_ff;
   logic q_store_ff;
   logic [VALUE_BITS-1:0] q_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= start;
      end
      q_op_ff     <= op_type'(op);
      q_status_ff <= (op_type'(op) == OP_QUERY) ? st : ST_OK;
      q_level_ff  <= k;
      q_addr_a_ff <= (op_type'(op) == OP_WRITE) ? IDX_BITS'(index) : IDX_BITS'(left);
      q_addr_b_ff <= IDX_BITS'(second);
      q_store_ff  <= ({{(32-FieldBits){1'b0}}, index} < 32'(DEPTH));
      q_value_ff  <= value;
   end

   assign q_valid  = q_valid_ff;
   assign q_op     = q_op_ff;
   assign q_status = q_status_ff;
   assign q_level  = q_level_ff;
   assign q_addr_a = q_addr_a_ff;
   assign q_addr_b = q_addr_b_ff;
   assign q_store  = q_store_ff;
   assign q_value  = q_value_ff;

endmodule

@@ rtl/core/rmmq_back.sv @@
// Back end: table memories, build sequencer and query read path.
module rmmq_back
   import rmmq_pkg::*;
#(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned LEVELS = 11,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned IDX_BITS = 10,
   parameter int unsigned LVL_BITS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  op_type                q_op,
   input  status_type            q_status,
   input  logic [LVL_BITS-1:0]   q_level,
   input  logic [IDX_BITS-1:0]   q_addr_a,
   input  logic [IDX_BITS-1:0]   q_addr_b,
   input  logic                  q_store,
   input  logic [VALUE_BITS-1:0] q_value,
   input  logic [CountBits-1:0]  count_used,
   output logic                  build_busy,
   output logic                  build_done,
   output logic                  rsp_strobe,
   output status_type            rsp_status,
   output logic [OutBits-1:0]    rsp_min,
   output logic [OutBits-1:0]    rsp_max
);

   localparam int unsigned AddrBits = LVL_BITS + IDX_BITS;
   localparam int unsigned Words = LEVELS << IDX_BITS;

   // Three ports each: port A and port B read, one write port
   logic [VALUE_BITS-1:0] min_mem [Words];
   logic [VALUE_BITS-1:0] max_mem [Words];

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_LAST = 3'b100
   } bstate_type;

   bstate_type bstate_ff, bstate_in;
   logic [LVL_BITS-1:0] lvl_ff, lvl_in;
   logic [IDX_BITS:0] pos_ff, pos_in;
   // pipeline of pending build writes
   logic wr_pend_ff, wr_pend_in;
   logic [AddrBits-1:0] wr_addr_ff, wr_addr_in;

   logic [AddrBits-1:0] ra_addr, rb_addr;
   logic [VALUE_BITS-1:0] mina_ff, minb_ff, maxa_ff, maxb_ff;
   logic we;
   logic [AddrBits-1:0] waddr;
   logic [VALUE_BITS-1:0] wmin, wmax;
   logic [IDX_BITS:0] half;
   logic [IDX_BITS+1:0] span;
   logic [IDX_BITS+1:0] next_pos_end;

   // Query stage
   logic qv_ff;
   status_type qs_ff;
   logic q_is_query_ff;

   always_comb begin
      half = (IDX_BITS+1)'(1) << (lvl_ff - 1'b1);
      span = (IDX_BITS+2)'(1) << lvl_ff;
      next_pos_end = {1'b0, pos_ff} + span;
      bstate_in = bstate_ff;
      lvl_in = lvl_ff;
      pos_in = pos_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = {(lvl_ff), pos_ff[IDX_BITS-1:0]};
      build_done = 1'b0;
      ra_addr = {q_level, q_addr_a};
      rb_addr = {q_level, q_addr_b};
      unique case (bstate_ff)
         B_IDLE: begin
            if (q_valid && q_op == OP_BUILD) begin
               bstate_in = B_READ;
               lvl_in = LVL_BITS'(1);
               pos_in = '0;
            end
         end
         B_READ: begin
            ra_addr = {lvl_ff - 1'b1, pos_ff[IDX_BITS-1:0]};
            rb_addr = {lvl_ff - 1'b1, IDX_BITS'(pos_ff + half)};
            if (lvl_ff >= LVL_BITS'(LEVELS) ||
                (IDX_BITS+2)'(count_used) < span) begin
               bstate_in = B_LAST;
            end else if (next_pos_end <= (IDX_BITS+2)'(count_used)) begin
               wr_pend_in = 1'b1;
               pos_in = pos_ff + 1'b1;
            end else begin
               // level finished; hold in B_READ while its last write is pending so it lands
               wr_pend_in = 1'b0;
               bstate_in = (wr_pend_ff) ? B_READ : B_READ;
               if (!wr_pend_ff) begin
                  lvl_in = lvl_ff + 1'b1;
                  pos_in = '0;
               end
            end
         end
         B_LAST: begin
            build_done = 1'b1;
            bstate_in = B_IDLE;
         end
         default: bstate_in = B_IDLE;
      endcase
   end

   always_comb begin
      if (q_valid && q_op == OP_WRITE && q_store && bstate_ff == B_IDLE) begin
         we = 1'b1;
         waddr = {LVL_BITS'(0), q_addr_a};
         wmin = q_value;
         wmax = q_value;
      end else begin
         we = wr_pend_ff;
         waddr = wr_addr_ff;
         wmin = ($signed(mina_ff) < $signed(minb_ff)) ? mina_ff : minb_ff;
         wmax = ($signed(maxa_ff) > $signed(maxb_ff)) ? maxa_ff : maxb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         min_mem[waddr] <= wmin;
         max_mem[waddr] <= wmax;
      end
      mina_ff <= min_mem[ra_addr];
      minb_ff <= min_mem[rb_addr];
      maxa_ff <= max_mem[ra_addr];
      maxb_ff <= max_mem[rb_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff <= B_IDLE;
         wr_pend_ff <= 1'b0;
         qv_ff <= 1'b0;
      end else begin
         bstate_ff <= bstate_in;
         wr_pend_ff <= wr_pend_in;
         qv_ff <= q_valid && q_op != OP_BUILD;
      end
      lvl_ff <= lvl_in;
      pos_ff <= pos_in;
      wr_addr_ff <= wr_addr_in;
      qs_ff <= (q_valid && q_op == OP_QUERY) ? q_status : ST_OK;
   end

   // Result: non-build results in the cycle after the memory read,
   // build result when the sequencer finishes
   logic ok;
   always_comb begin
      ok = (qs_ff == ST_OK) && qv_ff && q_is_query_ff;
      rsp_strobe = qv_ff || build_done;
      rsp_status = build_done ? ST_OK : qs_ff;
      rsp_min = ok ? OutBits'(($signed(mina_ff) < $signed(minb_ff)) ? mina_ff : minb_ff)
                   : '0;
      rsp_max = ok ? OutBits'(($signed(maxa_ff) > $signed(maxb_ff)) ? maxa_ff : maxb_ff)
                   : '0;
   end

   always_ff @(posedge clock) begin
      q_is_query_ff <= q_op == OP_QUERY;
   end

   assign build_busy = (bstate_ff != B_IDLE) || (q_valid && q_op == OP_BUILD);

endmodule
